// File: rtl/pip_pkg.sv
// Shared types and constants of the point-in-polygon slice test.
`timescale 1ns / 1ps

package pip_pkg;

	localparam int FRAC_BITS   = 8;   // fraction bits of a Q16.8 coordinate
	localparam int PT_W        = 16;  // width of an integer query coordinate
	localparam int IN_COORD_W  = 24;  // width of a vertex coordinate field
	localparam int VIDX_W      = 6;   // width of the vertex slot field
	localparam int VCOUNT_W    = 7;   // width of the vertex count register
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BBOX_EN      = 2'd1;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RST  = 7'd3;
	localparam logic                BBOX_EN_RST = 1'b1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LAST,
		ST_MUL_L,
		ST_MUL_R,
		ST_DONE
	} pip_state_t;

endpackage

// File: rtl/pip_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module pip_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/point_in_polygon_slice_test.sv
// Top level of the point-in-polygon slice test: vertex store, sequencer and edge unit.
`timescale 1ns / 1ps

// Usage.
// An item is taken on a rising edge with start high and busy low. req_type selects
// a load (vertex_index, vertex_x/y/z written to the store) or a query (point_x/y/z).
// A load is written at the accepting edge, produces no result and leaves busy low,
// so loads may be issued on every cycle.
// A query raises busy and walks the vertices in use one after another through a
// single shared multiplier, one product per cycle. The bounding box is gathered
// on the same walk and applied at the end. Once the walk is through, done pulses
// with inside_res; busy falls in the cycle done is shown, so the next item may be
// accepted then. A query with a vertex count of zero answers 0 in the next cycle.
// done is high for exactly one cycle; the receiver cannot stall the block.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready and is meant to be written only while the block is idle.
// Reset clears the sequencer and the registers to their reset values; the vertex
// store is not cleared and must be loaded before it is queried.

module point_in_polygon_slice_test #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [pip_pkg::VIDX_W-1:0]         vertex_index,
	input  logic signed [pip_pkg::IN_COORD_W-1:0] vertex_x,
	input  logic signed [pip_pkg::IN_COORD_W-1:0] vertex_y,
	input  logic signed [pip_pkg::IN_COORD_W-1:0] vertex_z,
	input  logic signed [pip_pkg::PT_W-1:0]    point_x,
	input  logic signed [pip_pkg::PT_W-1:0]    point_y,
	input  logic signed [pip_pkg::PT_W-1:0]    point_z,
	output logic                               done,
	output logic                               inside_res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pip_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pip_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import pip_pkg::*;

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int PQ_W  = PT_W + FRAC_BITS;
	localparam int DW    = ((COORD_WIDTH > PQ_W) ? COORD_WIDTH : PQ_W) + 1;
	localparam int PW    = 2 * DW;
	localparam int TW    = ((COORD_WIDTH - FRAC_BITS > PT_W) ? COORD_WIDTH - FRAC_BITS : PT_W);
	localparam int RAM_W = 3 * COORD_WIDTH;

	// Truncation of a Q16.8 value toward zero to its integer part.
	function automatic logic signed [TW-1:0] trunc_int(input logic signed [COORD_WIDTH-1:0] q);
		logic signed [COORD_WIDTH-1:0] biased;
		logic signed [COORD_WIDTH-FRAC_BITS-1:0] ip;
		biased = q[COORD_WIDTH-1] ? q + COORD_WIDTH'(signed'(255)) : q;
		ip = biased[COORD_WIDTH-1:FRAC_BITS];
		return TW'(ip);
	endfunction

	pip_state_t state_q, state_d;

	logic [VCOUNT_W-1:0] vertex_count_q;
	logic                bbox_en_q;

	logic [AW-1:0] idx_q, last_q, rd_addr;
	logic          ram_we;
	logic [RAM_W-1:0] wdata, rdata;

	logic signed [PT_W-1:0] px_q, py_q, pz_q;
	logic signed [COORD_WIDTH-1:0] xj_q, yj_q;
	logic signed [COORD_WIDTH-1:0] xi, yi, zi;
	logic signed [TW-1:0] tx, ty, tz;
	logic signed [TW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, lo_z_q, hi_z_q;
	logic signed [TW-1:0] pxe, pye, pze;

	logic signed [PQ_W-1:0] bx, by;
	logic signed [DW-1:0] bx_e, by_e, xi_e, yi_e, xj_e, yj_e, d_e;
	logic signed [DW-1:0] op_a, op_b;
	logic signed [PW-1:0] prod, lhs_q, rhs_q;
	logic                 cond_q, neg_d_q, pend_q, parity_q;
	logic                 cross_hit, final_par, box_ok;
	logic                 done_q, inside_q;

	logic accept, slot_ok, count_zero;
	logic [AW-1:0] last_d;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign inside_res = inside_q;

	// Vertex store: x in the low third, then y, then z.
	assign slot_ok = (int'(vertex_index) < MAX_VERTICES);
	assign ram_we  = accept && (req_type == REQ_LOAD) && slot_ok;
	assign wdata   = {COORD_WIDTH'(vertex_z), COORD_WIDTH'(vertex_y), COORD_WIDTH'(vertex_x)};

	pip_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_VERTICES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(vertex_index)),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign xi = rdata[COORD_WIDTH-1:0];
	assign yi = rdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign zi = rdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign tx = trunc_int(xi);
	assign ty = trunc_int(yi);
	assign tz = trunc_int(zi);

	// Vertex count saturates at the store depth.
	assign count_zero = (vertex_count_q == '0);
	assign last_d = (int'(vertex_count_q) >= MAX_VERTICES) ? AW'(MAX_VERTICES - 1)
		: AW'(vertex_count_q - VCOUNT_W'(1));

	// Operands of the shared multiplier, all widened to DW.
	assign bx   = {px_q, 8'h00};
	assign by   = {py_q, 8'h00};
	assign bx_e = DW'(bx);
	assign by_e = DW'(by);
	assign xi_e = DW'(xi);
	assign yi_e = DW'(yi);
	assign xj_e = DW'(xj_q);
	assign yj_e = DW'(yj_q);
	assign d_e  = yj_e - yi_e;

	assign prod = PW'(op_a) * PW'(op_b);

	// The edge (i, j) crosses when the sign-corrected products compare below.
	assign cross_hit = neg_d_q ? (rhs_q < lhs_q) : (lhs_q < rhs_q);
	assign final_par = parity_q ^ (pend_q & cross_hit);

	assign pxe = TW'(px_q);
	assign pye = TW'(py_q);
	assign pze = TW'(pz_q);
	assign box_ok = (pze >= lo_z_q) && (pze <= hi_z_q) &&
		(!bbox_en_q || ((pxe >= lo_x_q) && (pxe <= hi_x_q) &&
		(pye >= lo_y_q) && (pye <= hi_y_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = idx_q;
		op_a    = bx_e - xi_e;
		op_b    = d_e;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_QUERY) && !count_zero) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				rd_addr = last_q;
				state_d = ST_LAST;
			end
			ST_LAST: begin
				state_d = ST_MUL_L;
			end
			ST_MUL_L: begin
				state_d = ST_MUL_R;
			end
			ST_MUL_R: begin
				rd_addr = idx_q + AW'(1);
				op_a    = xj_e - xi_e;
				op_b    = by_e - yi_e;
				state_d = (idx_q == last_q) ? ST_DONE : ST_MUL_L;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VCOUNT_RST;
			bbox_en_q      <= BBOX_EN_RST;
			done_q         <= 1'b0;
			inside_q       <= 1'b0;
			pend_q         <= 1'b0;
			parity_q       <= 1'b0;
			idx_q          <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VERTEX_COUNT: vertex_count_q <= cfg_data;
					REG_BBOX_EN:      bbox_en_q      <= cfg_data[0];
					default:          ;
				endcase
			end
			done_q   <= 1'b0;
			inside_q <= 1'b0;
			pend_q   <= (state_q == ST_MUL_R) ? cond_q : 1'b0;
			if (pend_q && cross_hit) begin
				parity_q <= !parity_q;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_QUERY)) begin
						idx_q    <= '0;
						parity_q <= 1'b0;
						if (count_zero) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_MUL_R: begin
					idx_q <= idx_q + AW'(1);
				end
				ST_DONE: begin
					done_q   <= 1'b1;
					inside_q <= box_ok & final_par;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_type == REQ_QUERY)) begin
					px_q   <= point_x;
					py_q   <= point_y;
					pz_q   <= point_z;
					last_q <= last_d;
				end
			end
			ST_LAST: begin
				// The last vertex opens the first edge and seeds the box.
				xj_q   <= xi;
				yj_q   <= yi;
				lo_x_q <= tx;
				hi_x_q <= tx;
				lo_y_q <= ty;
				hi_y_q <= ty;
				lo_z_q <= tz;
				hi_z_q <= tz;
			end
			ST_MUL_L: begin
				lhs_q   <= prod;
				cond_q  <= (yi_e > by_e) != (yj_e > by_e);
				neg_d_q <= d_e[DW-1];
				if (tx < lo_x_q) lo_x_q <= tx;
				if (tx > hi_x_q) hi_x_q <= tx;
				if (ty < lo_y_q) lo_y_q <= ty;
				if (ty > hi_y_q) hi_y_q <= ty;
				if (tz < lo_z_q) lo_z_q <= tz;
				if (tz > hi_z_q) hi_z_q <= tz;
			end
			ST_MUL_R: begin
				rhs_q <= prod;
				xj_q  <= xi;
				yj_q  <= yi;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result shown while a query is still running");

	a_query_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_QUERY)) |=> (busy || done_q))
		else $error("accepted query neither started nor answered");

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_R) |=> ((state_q == ST_MUL_L) || (state_q == ST_DONE)))
		else $error("edge sequencer left its two-cycle loop");

	a_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(state_q == ST_MUL_R))
		else $error("pending crossing without a finished edge");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the point-in-polygon slice test block.
`timescale 1ns / 1ps

module tb;
	import pip_pkg::*;

	localparam int SLOTS    = 64;
	localparam int CLK_HALF = 4;
	localparam int PT_MIN   = -(1 << (PT_W - 1));
	localparam int PT_MAX   = (1 << (PT_W - 1)) - 1;
	localparam int CFG_MAX  = (1 << CFG_DATA_W) - 1;

	// Register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		logic                         rtype;
		logic [VIDX_W-1:0]            idx;
		logic signed [IN_COORD_W-1:0] vx, vy, vz;
		logic signed [PT_W-1:0]       px, py, pz;
	} pip_item_t;

	typedef enum {ROW_LOAD, ROW_QUERY, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		pip_item_t             it;
		bit                    known;
		bit                    known_val;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
	} dir_row_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         start        = 1'b0;
	logic                         busy;
	logic                         req_type     = REQ_LOAD;
	logic [VIDX_W-1:0]            vertex_index = '0;
	logic signed [IN_COORD_W-1:0] vertex_x     = '0;
	logic signed [IN_COORD_W-1:0] vertex_y     = '0;
	logic signed [IN_COORD_W-1:0] vertex_z     = '0;
	logic signed [PT_W-1:0]       point_x      = '0;
	logic signed [PT_W-1:0]       point_y      = '0;
	logic signed [PT_W-1:0]       point_z      = '0;
	logic                         done;
	logic                         inside_res;
	logic                         cfg_valid    = 1'b0;
	logic                         cfg_ready;
	logic [CFG_IDX_W-1:0]         cfg_index    = '0;
	logic [CFG_DATA_W-1:0]        cfg_data     = '0;

	// Mirror of the polygon store and registers.
	logic signed [IN_COORD_W-1:0] x_mem [SLOTS];
	logic signed [IN_COORD_W-1:0] y_mem [SLOTS];
	logic signed [IN_COORD_W-1:0] z_mem [SLOTS];
	int unsigned model_count = 32'(VCOUNT_RST);
	bit          model_bbox  = BBOX_EN_RST;

	bit       inside_q [$];
	dir_row_t directed_rows [$];
	bit       want_inside;
	int       n_fail     = 0;
	int       idle_pct   = 0;
	int       items_sent = 0;

	point_in_polygon_slice_test u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.done         (done),
		.inside_res   (inside_res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Truncate toward zero, not toward minus infinity.
	function automatic longint trunc_q(longint q);
		return (q < 0) ? -((-q) >>> FRAC_BITS) : (q >>> FRAC_BITS);
	endfunction

	// Bounding box first, then the crossing count with exact cross-multiplied slopes.
	function automatic bit predict_inside(logic signed [PT_W-1:0] px, py, pz);
		int     n, j;
		longint lo_x, hi_x, lo_y, hi_y, lo_z, hi_z, tx, ty, tz;
		longint bx, by, xi, yi, xj, yj, d, lhs, rhs;
		bit     par;
		n = (model_count > SLOTS) ? SLOTS : int'(model_count);
		if (n == 0)
			return 1'b0;
		lo_x = 0;
		hi_x = 0;
		lo_y = 0;
		hi_y = 0;
		lo_z = 0;
		hi_z = 0;
		for (int i = 0; i < n; i++) begin
			tx = trunc_q(longint'(x_mem[VIDX_W'(i)]));
			ty = trunc_q(longint'(y_mem[VIDX_W'(i)]));
			tz = trunc_q(longint'(z_mem[VIDX_W'(i)]));
			if (i == 0 || tx < lo_x)
				lo_x = tx;
			if (i == 0 || tx > hi_x)
				hi_x = tx;
			if (i == 0 || ty < lo_y)
				lo_y = ty;
			if (i == 0 || ty > hi_y)
				hi_y = ty;
			if (i == 0 || tz < lo_z)
				lo_z = tz;
			if (i == 0 || tz > hi_z)
				hi_z = tz;
		end
		if (longint'(pz) < lo_z || longint'(pz) > hi_z)
			return 1'b0;
		if (model_bbox && (longint'(px) < lo_x || longint'(px) > hi_x ||
				longint'(py) < lo_y || longint'(py) > hi_y))
			return 1'b0;
		bx = longint'(px) * (1 << FRAC_BITS);
		by = longint'(py) * (1 << FRAC_BITS);
		par = 1'b0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = longint'(x_mem[VIDX_W'(i)]);
			yi = longint'(y_mem[VIDX_W'(i)]);
			xj = longint'(x_mem[VIDX_W'(j)]);
			yj = longint'(y_mem[VIDX_W'(j)]);
			if ((yi > by) != (yj > by)) begin
				d = yj - yi;
				lhs = (bx - xi) * d;
				rhs = (xj - xi) * (by - yi);
				par ^= (d > 0) ? (lhs < rhs) : (rhs < lhs);
			end
			j = i;
		end
		return par;
	endfunction

	function automatic pip_item_t make_item(logic rt, logic [VIDX_W-1:0] idx,
			logic signed [IN_COORD_W-1:0] vx, vy, vz, logic signed [PT_W-1:0] px, py, pz);
		pip_item_t it;
		it.rtype = rt;
		it.idx = idx;
		it.vx = vx;
		it.vy = vy;
		it.vz = vz;
		it.px = px;
		it.py = py;
		it.pz = pz;
		return it;
	endfunction

	function automatic void add_load(int idx, int x, int y, int z);
		dir_row_t row;
		row.kind = ROW_LOAD;
		row.it = make_item(REQ_LOAD, VIDX_W'(idx), IN_COORD_W'(x), IN_COORD_W'(y),
			IN_COORD_W'(z), '0, '0, '0);
		row.known = 1'b0;
		row.known_val = 1'b0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_query(int x, int y, int z, bit known = 0, bit val = 0);
		dir_row_t row;
		row.kind = ROW_QUERY;
		row.it = make_item(REQ_QUERY, '0, '0, '0, '0, PT_W'(x), PT_W'(y), PT_W'(z));
		row.known = known;
		row.known_val = val;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		dir_row_t row;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		directed_rows.push_back(row);
	endfunction

	function automatic int pick(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int clamp_pt(int v);
		return (v < PT_MIN) ? PT_MIN : ((v > PT_MAX) ? PT_MAX : v);
	endfunction

	function automatic logic signed [IN_COORD_W-1:0] to_q(int whole, bit on_grid);
		return IN_COORD_W'(whole * (1 << FRAC_BITS) +
			(on_grid ? 0 : int'($urandom_range(255))));
	endfunction

	task automatic send_item(pip_item_t it, bit known = 0, bit known_val = 0);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= it.rtype;
		vertex_index <= it.idx;
		vertex_x <= it.vx;
		vertex_y <= it.vy;
		vertex_z <= it.vz;
		point_x <= it.px;
		point_y <= it.py;
		point_z <= it.pz;
		do @(posedge clk); while (busy !== 1'b0);
		if (it.rtype == REQ_LOAD) begin
			x_mem[it.idx] = it.vx;
			y_mem[it.idx] = it.vy;
			z_mem[it.idx] = it.vz;
		end else begin
			inside_q.push_back(known ? known_val : predict_inside(it.px, it.py, it.pz));
		end
	endtask

	// Registers are only touched once every query has answered.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		start <= 1'b0;
		while (inside_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_VERTEX_COUNT: begin
				model_count = 32'(val);
			end
			REG_BBOX_EN: begin
				model_bbox = val[0];
			end
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	// One polygon: set the registers, load the vertices in use, then query around it.
	task automatic run_shape();
		int  sel, n, used, cx, cy, cz, r, zr, nq;
		bit  grid, wild;
		logic signed [IN_COORD_W-1:0] vx, vy, vz;
		sel = $urandom_range(99);
		if (sel < 4)
			n = 0;
		else if (sel < 10)
			n = pick(1, 2);
		else if (sel < 80)
			n = pick(3, 8);
		else if (sel < 93)
			n = pick(9, 24);
		else if (sel < 97)
			n = SLOTS;
		else
			n = pick(SLOTS + 1, CFG_MAX);
		write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(n));
		write_reg(REG_BBOX_EN, CFG_DATA_W'($urandom_range(CFG_MAX)));
		if ($urandom_range(7) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
				CFG_DATA_W'($urandom_range(CFG_MAX)));
		used = (n > SLOTS) ? SLOTS : n;
		cx = pick(PT_MIN, PT_MAX);
		cy = pick(PT_MIN, PT_MAX);
		cz = pick(PT_MIN, PT_MAX);
		sel = $urandom_range(99);
		r = (sel < 70) ? pick(2, 12) : ((sel < 95) ? pick(13, 300) : pick(301, PT_MAX));
		zr = pick(0, 4);
		grid = ($urandom_range(2) == 0);
		wild = ($urandom_range(9) == 0);
		for (int k = 0; k < used; k++) begin
			if (wild) begin
				vx = IN_COORD_W'($urandom);
				vy = IN_COORD_W'($urandom);
				vz = IN_COORD_W'($urandom);
			end else begin
				vx = to_q(clamp_pt(cx + pick(-r, r)), grid);
				vy = to_q(clamp_pt(cy + pick(-r, r)), grid);
				vz = to_q(clamp_pt(cz + pick(-zr, zr)), grid);
			end
			send_item(make_item(REQ_LOAD, VIDX_W'(k), vx, vy, vz, PT_W'($urandom),
				PT_W'($urandom), PT_W'($urandom)));
			items_sent++;
		end
		nq = pick(4, 12);
		repeat (nq) begin
			if ($urandom_range(9) == 0)
				send_item(make_item(REQ_LOAD, VIDX_W'($urandom), IN_COORD_W'($urandom),
					IN_COORD_W'($urandom), IN_COORD_W'($urandom),
					PT_W'($urandom), PT_W'($urandom), PT_W'($urandom)));
			else if ($urandom_range(4) == 0)
				send_item(make_item(REQ_QUERY, VIDX_W'($urandom), IN_COORD_W'($urandom),
					IN_COORD_W'($urandom), IN_COORD_W'($urandom),
					PT_W'($urandom), PT_W'($urandom), PT_W'($urandom)));
			else
				send_item(make_item(REQ_QUERY, VIDX_W'($urandom), IN_COORD_W'($urandom),
					IN_COORD_W'($urandom), IN_COORD_W'($urandom),
					PT_W'(clamp_pt(cx + pick(-r - 2, r + 2))),
					PT_W'(clamp_pt(cy + pick(-r - 2, r + 2))),
					PT_W'(clamp_pt(cz + pick(-zr - 2, zr + 2)))));
			items_sent++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (inside_q.size() == 0) begin
				$error("inside_res: result with no query pending, got %0b", inside_res);
				n_fail++;
			end else begin
				want_inside = inside_q.pop_front();
				if (inside_res !== want_inside) begin
					$error("inside_res: expected %0b, got %0b", want_inside, inside_res);
					n_fail++;
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Small right triangle at the origin, z spanning -1..1, reset register values.
		add_load(0, 0, 0, 0);
		add_load(1, 2560, 0, 256);
		add_load(2, 0, 2560, -256);
		add_query(2, 2, 0, 1, 1);
		add_query(2, 2, 2, 1, 0);
		add_query(11, 2, 0, 1, 0);
		add_query(8, 8, 0);
		add_query(0, 0, 0);
		// Box off: only the z range still gates the query.
		add_reg(REG_BBOX_EN, 7'h7E);
		add_query(-5, 3, 1);
		add_query(2, 2, -2, 1, 0);
		add_reg(REG_VERTEX_COUNT, 0);
		add_query(2, 2, 0, 1, 0);
		// Writes to undecoded indexes must leave the count at zero.
		add_reg(REG_SPARE_2, 7'h7F);
		add_reg(REG_SPARE_3, 7'h00);
		add_query(0, 0, 0, 1, 0);
		// A vertex at -1.5 truncates to -1 for the box.
		add_load(3, -384, 384, 0);
		add_reg(REG_VERTEX_COUNT, 4);
		add_reg(REG_BBOX_EN, 7'h01);
		add_query(-1, 1, 0);
		add_query(-2, 1, 0, 1, 0);
		add_load(0, -8388608, -8388608, -8388608);
		add_load(1, 8388607, -8388608, 8388607);
		add_load(2, -8388608, 8388607, 0);
		add_reg(REG_VERTEX_COUNT, 3);
		add_query(PT_MIN, PT_MIN, PT_MIN);
		add_query(PT_MAX, PT_MAX, PT_MAX);
		add_query(0, 0, 0);
		add_query(PT_MIN, PT_MAX, 0);
		add_load(SLOTS - 1, 8388607, 8388607, 8388607);
		add_query(PT_MAX, PT_MIN, 0);

		idle_pct = 16;
		foreach (directed_rows[k]) begin
			case (directed_rows[k].kind)
				ROW_REG: begin
					write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
				end
				default: begin
					send_item(directed_rows[k].it, directed_rows[k].known,
						directed_rows[k].known_val);
				end
			endcase
		end

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 16 : ((ph == 1) ? 56 : 0);
			while (items_sent < (ph + 1) * 350)
				run_shape();
		end
		start <= 1'b0;

		while (inside_q.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);
		if (n_fail == 0)
			$display("PASS point_in_polygon_slice_test");
		else
			$display("FAIL point_in_polygon_slice_test");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAIL point_in_polygon_slice_test");
		$finish;
	end

endmodule
